[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// when pre holds, post holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

[sv/ctq_pkg.sv]
// ----------------------------------------------------------------------------
// ctq_pkg
// op and result codes shared by the timer queue and its channel interfaces
// ----------------------------------------------------------------------------
package ctq_pkg;

	typedef logic [1:0] op_t;
	typedef logic [2:0] kind_t;

	localparam op_t OP_CREATE = 2'd0;
	localparam op_t OP_CANCEL = 2'd1;
	localparam op_t OP_TICK   = 2'd2;

	localparam kind_t KIND_CREATED   = 3'd0;
	localparam kind_t KIND_FULL      = 3'd1;
	localparam kind_t KIND_CANCELLED = 3'd2;
	localparam kind_t KIND_NOT_FOUND = 3'd3;
	localparam kind_t KIND_EXPIRED   = 3'd4;

	// most expiries emitted per tick
	localparam int MAX_OUT = 16;
	localparam int N_W     = $clog2(MAX_OUT + 1);

endpackage

[sv/ctq_if.sv]
// ----------------------------------------------------------------------------
// ctq_if
// valid/ready channels for timer queue commands and result words
// ----------------------------------------------------------------------------
interface ctq_cmd_if import ctq_pkg::*; ();
	logic        valid;
	logic        ready;
	op_t         op;
	logic [31:0] timeout_ms;
	logic [31:0] handle;

	modport source (output valid, output op, output timeout_ms, output handle, input ready);
	modport sink (input valid, input op, input timeout_ms, input handle, output ready);
endinterface

interface ctq_evt_if import ctq_pkg::*; ();
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [31:0] timer_handle;
	logic        became_earliest;
	logic        last;

	modport source (output valid, output kind, output timer_handle, output became_earliest,
		output last, input ready);
	modport sink (input valid, input kind, input timer_handle, input became_earliest,
		input last, output ready);
endinterface

[sv/cancellable_timer_queue.sv]
// ----------------------------------------------------------------------------
// cancellable_timer_queue
// Table of pending one-shot timers with a millisecond clock. Deadlines and
// handles sit in two single-port synchronous memories of ENTRIES words; valid
// bits are flip-flops cleared by reset, so no clearing pass is needed. A
// create or cancel walks the whole table once through the memory read port;
// a tick walks it once per emitted timer plus a final empty scan, and one
// that expires 16 timers ends without the empty scan and leaves the rest
// pending. An unused op is taken without a scan or a result word. A stalled
// result port holds the block until its word is taken. The next command is
// taken while the last result word still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cancellable_timer_queue import ctq_pkg::*; #(
	parameter int ENTRIES   = 16,
	parameter int TIME_BITS = 48
) (
	input logic       clk,
	input logic       arst_n,
	ctq_cmd_if.sink   cmd,
	ctq_evt_if.source evt
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	// storage
	logic [TIME_BITS-1:0] mem_dl [ENTRIES];
	logic [31:0]          mem_h  [ENTRIES];
	logic [ENTRIES-1:0]   valid_q;

	// control
	logic [2:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 act_s1;
	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [TIME_BITS-1:0] rd_dl_s1;
	logic [31:0]          rd_h_s1;
	logic [TIME_BITS-1:0] now_q;
	logic [31:0]          last_handle_q;
	logic                 found_q;
	logic [N_W-1:0]       n_q;
	logic                 pend_q;

	// per command
	op_t                  op_q;
	logic [31:0]          key_h_q;
	logic [TIME_BITS-1:0] new_dl_q;
	logic                 early_q;
	logic [IDX_W-1:0]     sel_idx_q;
	logic [TIME_BITS-1:0] best_dl_q;
	logic [31:0]          best_h_q;
	logic [31:0]          pend_h_q;

	// output register
	logic                 ov_q;
	kind_t                o_kind_q;
	logic [31:0]          o_h_q;
	logic                 o_early_q;
	logic                 o_last_q;

	logic                 accept;
	logic                 out_free;
	logic                 create_beats;
	logic                 cancel_match;
	logic                 tick_pick;
	logic                 upd_sel;
	logic                 early_clr;
	logic                 push;
	kind_t                push_kind;
	logic [31:0]          push_h;
	logic                 push_early;
	logic                 push_last;
	logic                 wr_en;
	logic                 clr_en;
	logic                 take;
	logic                 pend_done;
	logic [2:0]           state_d;

	assign cmd.ready           = (state_q == ST_IDLE);
	assign accept              = cmd.valid && cmd.ready;
	assign out_free            = !ov_q || evt.ready;
	assign evt.valid           = ov_q;
	assign evt.kind            = o_kind_q;
	assign evt.timer_handle    = o_h_q;
	assign evt.became_earliest = o_early_q;
	assign evt.last            = o_last_q;

	// compare the entry read back against the command
	always_comb begin
		create_beats = v_s1 && ((rd_dl_s1 < new_dl_q) ||
			((rd_dl_s1 == new_dl_q) && (rd_h_s1 < key_h_q)));
		cancel_match = v_s1 && (rd_h_s1 == key_h_q);
		tick_pick    = v_s1 && (rd_dl_s1 <= now_q) && (!found_q ||
			(rd_dl_s1 < best_dl_q) || ((rd_dl_s1 == best_dl_q) && (rd_h_s1 < best_h_q)));
		upd_sel   = 1'b0;
		early_clr = 1'b0;
		if (act_s1) begin
			unique case (op_q)
				OP_CREATE: begin
					upd_sel   = !v_s1 && !found_q;
					early_clr = create_beats;
				end
				OP_CANCEL: upd_sel = cancel_match && !found_q;
				OP_TICK:   upd_sel = tick_pick;
				default:   upd_sel = 1'b0;
			endcase
		end
	end

	// end of scan: result words, table updates, next state
	always_comb begin
		push       = 1'b0;
		push_kind  = KIND_EXPIRED;
		push_h     = pend_h_q;
		push_early = 1'b0;
		push_last  = 1'b0;
		wr_en      = 1'b0;
		clr_en     = 1'b0;
		take       = 1'b0;
		pend_done  = 1'b0;
		state_d    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd.op == OP_CREATE || cmd.op == OP_CANCEL ||
					cmd.op == OP_TICK)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE: begin
				unique case (op_q)
					OP_CREATE: begin
						if (out_free) begin
							push       = 1'b1;
							push_last  = 1'b1;
							push_kind  = found_q ? KIND_CREATED : KIND_FULL;
							push_h     = found_q ? key_h_q : 32'd0;
							push_early = found_q && early_q;
							wr_en      = found_q;
							state_d    = ST_IDLE;
						end
					end
					OP_CANCEL: begin
						if (out_free) begin
							push      = 1'b1;
							push_last = 1'b1;
							push_kind = found_q ? KIND_CANCELLED : KIND_NOT_FOUND;
							push_h    = key_h_q;
							clr_en    = found_q;
							state_d   = ST_IDLE;
						end
					end
					OP_TICK: begin
						if (found_q) begin
							// previous expiry is not last: another one follows
							if (!pend_q || out_free) begin
								push    = pend_q;
								clr_en  = 1'b1;
								take    = 1'b1;
								state_d = (n_q == N_W'(MAX_OUT - 1)) ? ST_FLUSH : ST_SCAN;
							end
						end else if (!pend_q) begin
							state_d = ST_IDLE;
						end else if (out_free) begin
							push      = 1'b1;
							push_last = 1'b1;
							pend_done = 1'b1;
							state_d   = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_FLUSH: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					pend_done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			act_s1        <= 1'b0;
			v_s1          <= 1'b0;
			valid_q       <= '0;
			now_q         <= '0;
			last_handle_q <= '0;
			found_q       <= 1'b0;
			n_q           <= '0;
			pend_q        <= 1'b0;
			ov_q          <= 1'b0;
		end else begin
			state_q <= state_d;
			act_s1  <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				v_s1  <= valid_q[idx_q];
				idx_q <= idx_q + 1'b1;
			end
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				n_q     <= '0;
				if (cmd.op == OP_TICK) begin
					now_q <= now_q + 1'b1;
				end
			end
			if (upd_sel) begin
				found_q <= 1'b1;
			end
			if (wr_en) begin
				valid_q[sel_idx_q] <= 1'b1;
				last_handle_q      <= key_h_q;
			end
			if (clr_en) begin
				valid_q[sel_idx_q] <= 1'b0;
			end
			if (take) begin
				pend_q  <= 1'b1;
				n_q     <= n_q + 1'b1;
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (pend_done) begin
				pend_q <= 1'b0;
			end
			if (push) begin
				ov_q <= 1'b1;
			end else if (evt.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= cmd.op;
			key_h_q  <= (cmd.op == OP_CREATE) ? last_handle_q + 32'd1 : cmd.handle;
			new_dl_q <= now_q + {{(TIME_BITS - 32){1'b0}}, cmd.timeout_ms};
			early_q  <= 1'b1;
		end
		if (state_q == ST_SCAN) begin
			idx_s1   <= idx_q;
			rd_dl_s1 <= mem_dl[idx_q];
			rd_h_s1  <= mem_h[idx_q];
		end
		if (early_clr) begin
			early_q <= 1'b0;
		end
		if (upd_sel) begin
			sel_idx_q <= idx_s1;
			best_dl_q <= rd_dl_s1;
			best_h_q  <= rd_h_s1;
		end
		if (wr_en) begin
			mem_dl[sel_idx_q] <= new_dl_q;
			mem_h[sel_idx_q]  <= key_h_q;
		end
		if (take) begin
			pend_h_q <= best_h_q;
		end
		if (push) begin
			o_kind_q  <= push_kind;
			o_h_q     <= push_h;
			o_early_q <= push_early;
			o_last_q  <= push_last;
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, n_q <= N_W'(MAX_OUT), "too many expiries")
	`ASSERT_ALWAYS(a_mid_expired, clk, arst_n, !ov_q || o_last_q || (o_kind_q == KIND_EXPIRED), "bad kind")
	`ASSERT_ALWAYS(a_no_pending_accept, clk, arst_n, !accept || !pend_q, "accept with expiry held")
	`ASSERT_NEXT(a_create_sets_valid, clk, arst_n, wr_en, valid_q[$past(sel_idx_q)], "slot not valid")

endmodule

[test/tb_ctq_event_check.sv]
// ----------------------------------------------------------------------------
// tb_ctq_event_check
// Watches the command and result channels of the timer queue, keeps its own
// copy of the timer table and clock, and compares every result word with the
// oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module tb_ctq_event_check import ctq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ctq_cmd_if          cmd,
	ctq_evt_if          evt,
	output int          waiting,
	output logic [31:0] issued_handle,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES   = 16;
	localparam int TIME_BITS = 48;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] timer_handle;
		logic        became_earliest;
		logic        last;
	} result_word_t;

	logic                 slot_busy[ENTRIES];
	logic [TIME_BITS-1:0] slot_deadline[ENTRIES];
	logic [31:0]          slot_handle[ENTRIES];
	logic [TIME_BITS-1:0] now_ms;
	logic [31:0]          handle_ctr;

	result_word_t due_words[$];
	result_word_t head;
	int           err_cnt = 0;

	assign fail_count = err_cnt;

	// slot a fires ahead of slot b: deadline first, then handle
	function automatic bit ordered_ahead(int a, int b);
		if (slot_deadline[a] != slot_deadline[b])
			return slot_deadline[a] < slot_deadline[b];
		return slot_handle[a] < slot_handle[b];
	endfunction

	task automatic apply_command(op_t op, logic [31:0] tmo, logic [31:0] hdl);
		int           i;
		int           slot;
		int           best;
		int           n;
		bit           early;
		result_word_t w;
		case (op)
			OP_CREATE: begin
				slot = -1;
				for (i = 0; i < ENTRIES; i++)
					if (!slot_busy[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					due_words.push_back('{KIND_FULL, 32'd0, 1'b0, 1'b1});
				end else begin
					handle_ctr          = handle_ctr + 32'd1;
					slot_busy[slot]     = 1'b1;
					slot_deadline[slot] = now_ms + {{(TIME_BITS-32){1'b0}}, tmo};
					slot_handle[slot]   = handle_ctr;
					early = 1'b1;
					for (i = 0; i < ENTRIES; i++)
						if (i != slot && slot_busy[i] && ordered_ahead(i, slot))
							early = 1'b0;
					due_words.push_back('{KIND_CREATED, handle_ctr, early, 1'b1});
				end
			end
			OP_CANCEL: begin
				slot = -1;
				for (i = 0; i < ENTRIES; i++)
					if (slot < 0 && slot_busy[i] && slot_handle[i] == hdl)
						slot = i;
				if (slot < 0) begin
					due_words.push_back('{KIND_NOT_FOUND, hdl, 1'b0, 1'b1});
				end else begin
					slot_busy[slot] = 1'b0;
					due_words.push_back('{KIND_CANCELLED, hdl, 1'b0, 1'b1});
				end
			end
			OP_TICK: begin
				now_ms = now_ms + 1'b1;
				n = 0;
				while (n < MAX_OUT) begin
					best = -1;
					for (i = 0; i < ENTRIES; i++)
						if (slot_busy[i] && slot_deadline[i] <= now_ms)
							if (best < 0 || ordered_ahead(i, best))
								best = i;
					if (best < 0)
						break;
					slot_busy[best] = 1'b0;
					due_words.push_back('{KIND_EXPIRED, slot_handle[best], 1'b0, 1'b0});
					n++;
				end
				if (n > 0) begin
					w = due_words[due_words.size()-1];
					w.last = 1'b1;
					due_words[due_words.size()-1] = w;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_busy[i]     = 1'b0;
				slot_deadline[i] = '0;
				slot_handle[i]   = '0;
			end
			now_ms     = '0;
			handle_ctr = '0;
			due_words.delete();
			waiting       <= 0;
			issued_handle <= '0;
		end else begin
			// result words first, a command accepted now cannot answer at once
			if (evt.valid && evt.ready) begin
				if (due_words.size() == 0) begin
					$error("unexpected result word: kind %0d handle %0h",
						evt.kind, evt.timer_handle);
					err_cnt++;
				end else begin
					head = due_words.pop_front();
					if (evt.kind !== head.kind) begin
						$error("kind: expected %0d, got %0d", head.kind, evt.kind);
						err_cnt++;
					end
					if (evt.timer_handle !== head.timer_handle) begin
						$error("timer_handle: expected %0h, got %0h",
							head.timer_handle, evt.timer_handle);
						err_cnt++;
					end
					if (evt.became_earliest !== head.became_earliest) begin
						$error("became_earliest: expected %0b, got %0b",
							head.became_earliest, evt.became_earliest);
						err_cnt++;
					end
					if (evt.last !== head.last) begin
						$error("last: expected %0b, got %0b", head.last, evt.last);
						err_cnt++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				apply_command(cmd.op, cmd.timeout_ms, cmd.handle);
			waiting       <= due_words.size();
			issued_handle <= handle_ctr;
		end
	end

endmodule

[test/tb_cancellable_timer_queue.sv]
// ----------------------------------------------------------------------------
// tb_cancellable_timer_queue
// Drives create, cancel and tick commands into the timer queue: a directed
// opening (quiet tick, zero and maximum timeouts, deadline ties, misses,
// unused op, a full table expiring in one tick), then random traffic in
// phases with and without sender idling and receiver stalls. Checking sits in the
// event checker beside the block.
// ----------------------------------------------------------------------------
module tb_cancellable_timer_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import ctq_pkg::*;

	localparam op_t OP_UNUSED       = 2'd3;
	localparam int  STALL_LIMIT     = 4000;
	localparam int  DRAIN_CYCLES    = 350;
	localparam int  ITEMS_PER_PHASE = 33;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          waiting;
	logic [31:0] issued_handle;
	int          fail_count;
	int          quiet_cycles = 0;

	ctq_cmd_if cmd_ch();
	ctq_evt_if evt_ch();

	cancellable_timer_queue uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.evt   (evt_ch)
	);

	tb_ctq_event_check ev_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd_ch),
		.evt          (evt_ch),
		.waiting      (waiting),
		.issued_handle(issued_handle),
		.fail_count   (fail_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		evt_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// give up when no word moves on either channel for too long
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(op_t op, logic [31:0] tmo, logic [31:0] hdl);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= op;
		cmd_ch.timeout_ms <= tmo;
		cmd_ch.handle     <= hdl;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	initial begin
		int          ph;
		int          n;
		int          r;
		logic [31:0] tmo;
		logic [31:0] hdl;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.op         <= OP_CREATE;
		cmd_ch.timeout_ms <= '0;
		cmd_ch.handle     <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_TICK, '0, '0);                 // nothing pending
		send_word(OP_CREATE, 32'd0, '1);            // handle 1, earliest
		send_word(OP_CREATE, 32'hFFFF_FFFF, '1);    // handle 2, far out
		send_word(OP_CREATE, 32'd0, '0);            // ties with handle 1, not earliest
		send_word(OP_CANCEL, '1, 32'hFFFF_FFFF);
		send_word(OP_CANCEL, '1, 32'd0);
		send_word(OP_UNUSED, '1, '1);
		send_word(OP_TICK, '1, '1);                 // handles 1 and 3 expire
		send_word(OP_CANCEL, '0, 32'd2);
		// fill the table, refuse one more, then drain it all in one tick
		for (int i = 0; i < 16; i++)
			send_word(OP_CREATE, 32'd1, $urandom);
		send_word(OP_CREATE, 32'd1, '0);
		send_word(OP_TICK, '0, '0);
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 36 : 0;
			stall_pct = (ph == 2) ? 49 : (ph == 3) ? 36 : 0;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				r   = $urandom_range(99);
				tmo = $urandom;
				hdl = $urandom;
				if (r < 45) begin
					if ($urandom_range(9) != 0)
						tmo = $urandom_range(20);
					send_word(OP_CREATE, tmo, hdl);
				end else if (r < 75) begin
					send_word(OP_TICK, tmo, hdl);
				end else if (r < 95) begin
					// mostly aim at recently issued handles
					if ($urandom_range(4) != 0)
						hdl = issued_handle - $urandom_range(24);
					send_word(OP_CANCEL, tmo, hdl);
				end else begin
					send_word(OP_UNUSED, tmo, hdl);
					n--;
				end
				n++;
			end
			wait_drained();
		end

		idle_pct  = 0;
		stall_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && waiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[cancellable_timer_queue.f]
+incdir+sv
sv/ctq_pkg.sv
sv/ctq_if.sv
sv/cancellable_timer_queue.sv
test/tb_ctq_event_check.sv
test/tb_cancellable_timer_queue.sv
